// ----- sv/first_fit_heap_allocator_top_defines.svh -----
// assertion macros used by the allocator sequencer
// expects signals clk and rst in the including module
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- sv/ffa_pkg.sv -----
// constants, types and status codes of the first-fit heap allocator
// no dependencies
package ffa_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 40;
  localparam int GRAN_BYTES   = 8;
  localparam int GRAN_SH      = $clog2(GRAN_BYTES);
  localparam int NG           = ARENA_BYTES / GRAN_BYTES;
  localparam int IDX_W        = $clog2(NG);
  localparam int OFF_W        = IDX_W + 1;
  localparam int HDR_G        = HEADER_BYTES / GRAN_BYTES;
  localparam int SPLIT_G      = (HEADER_BYTES + GRAN_BYTES) / GRAN_BYTES;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OFF_W-1:0] off_t;

  // one block header, offsets and sizes in granules
  typedef struct packed {
    logic start;
    logic is_free;
    logic has_prev;
    idx_t size;
    idx_t prev;
  } hdr_t;

  typedef struct packed {
    off_t a;
    off_t b;
    logic sub;
  } alu_req_t;

  typedef struct packed {
    logic carry;
    off_t res;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2,
    ST_DBL = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
  } res_t;

endpackage

// ----- sv/ffa_alu.sv -----
// shared add / subtract unit of the allocator sequencer
// depends on ffa_pkg
module ffa_alu
  import ffa_pkg::*;
(
  input  alu_req_t q,
  output alu_rsp_t r
);

  off_t bop;

  assign bop = q.sub ? ~q.b : q.b;
  assign {r.carry, r.res} = {1'b0, q.a} + {1'b0, bop} + {{OFF_W{1'b0}}, q.sub};

endmodule

// ----- sv/ffa_seq.sv -----
// sequencer with block header memory: first-fit walk, split, free and coalesce
// depends on ffa_pkg, ffa_alu (through alu_q / alu_r) and the defines header
`include "first_fit_heap_allocator_top_defines.svh"
module ffa_seq
  import ffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_size,
  input  logic [15:0] in_addr,
  output alu_req_t    alu_q,
  input  alu_rsp_t    alu_r,
  output logic        done,
  output res_t        res,
  input  logic        done_ack
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WALK, S_WEV, S_FOUND, S_SPLW, S_FINO, S_NOFIT,
    S_FCHK, S_FEV, S_FPV, S_FNX, S_FNE, S_FLK, S_FWB, S_DONE
  } state_t;

  state_t      state;
  off_t        ht;
  off_t        need;
  logic [15:0] p;
  off_t        o;
  idx_t        last;
  logic        have_last;
  idx_t        blk;
  hdr_t        hb;
  idx_t        na;
  idx_t        nb;
  idx_t        clr;

  logic [$bits(hdr_t)-1:0] mem [NG];
  hdr_t rd;
  logic we;
  idx_t waddr;
  idx_t raddr;
  hdr_t wdata;

  off_t        need_c;
  off_t        walk_end;
  logic        split_c;
  off_t        n_c;
  off_t        nn_c;
  logic [OFF_W+1:0] top_c;
  logic        fit_ok;
  logic        bad_c;
  idx_t        b_c;
  off_t        e_c;
  off_t        nn2_c;

  function automatic logic [15:0] pay_addr(off_t x);
    logic [OFF_W+3:0] t;
    t = (OFF_W+4)'(x) + (OFF_W+4)'(HDR_G);
    pay_addr = 16'(t << GRAN_SH);
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= hdr_t'(mem[raddr]);
  end

  assign need_c   = OFF_W'((17'(in_size) + 17'(GRAN_BYTES - 1)) >> GRAN_SH);
  assign walk_end = o + OFF_W'(HDR_G) + OFF_W'(rd.size);
  assign split_c  = alu_r.res > OFF_W'(SPLIT_G);
  assign n_c      = o + OFF_W'(HDR_G) + need;
  assign nn_c     = o + OFF_W'(HDR_G) + OFF_W'(hb.size);
  assign top_c    = {1'b0, alu_r.carry, alu_r.res} + (OFF_W+2)'(HDR_G);
  assign fit_ok   = top_c <= (OFF_W+2)'(NG);
  assign bad_c    = (ht == '0) || (p < 16'(HEADER_BYTES)) ||
                    ({1'b0, p} >= 17'({ht, {GRAN_SH{1'b0}}})) ||
                    (p[GRAN_SH-1:0] != '0);
  assign b_c      = IDX_W'((17'(p) >> GRAN_SH) - 17'(HDR_G));
  assign e_c      = alu_r.res + OFF_W'(HDR_G);
  assign nn2_c    = OFF_W'(na) + OFF_W'(HDR_G) + OFF_W'(rd.size);

  assign in_ready = state == S_IDLE;
  assign done     = state == S_DONE;

  always_comb begin
    we    = 1'b0;
    waddr = blk;
    wdata = hb;
    raddr = o[IDX_W-1:0];
    alu_q = '{a: '0, b: '0, sub: 1'b1};
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      S_WEV: begin
        alu_q = '{a: OFF_W'(rd.size), b: need, sub: 1'b1};
      end
      S_FOUND: begin
        alu_q = '{a: OFF_W'(hb.size), b: need, sub: 1'b1};
        raddr = nn_c[IDX_W-1:0];
        if (split_c) begin
          we    = 1'b1;
          waddr = n_c[IDX_W-1:0];
          wdata = '{start: 1'b1, is_free: 1'b1, has_prev: 1'b1,
                    size: IDX_W'(alu_r.res - OFF_W'(HDR_G)), prev: o[IDX_W-1:0]};
        end
      end
      S_SPLW: begin
        we    = 1'b1;
        waddr = nb;
        wdata = rd;
        wdata.has_prev = 1'b1;
        wdata.prev     = na;
      end
      S_FINO: begin
        we    = 1'b1;
        waddr = o[IDX_W-1:0];
      end
      S_NOFIT: begin
        alu_q = '{a: ht, b: need, sub: 1'b0};
        if (fit_ok) begin
          we    = 1'b1;
          waddr = ht[IDX_W-1:0];
          wdata = '{start: 1'b1, is_free: 1'b0, has_prev: have_last,
                    size: need[IDX_W-1:0], prev: have_last ? last : '0};
        end
      end
      S_FCHK: begin
        raddr = b_c;
      end
      S_FEV: begin
        raddr = rd.prev;
      end
      S_FPV: begin
        if (rd.start && rd.is_free) begin
          we          = 1'b1;
          wdata.start = 1'b0;
        end
      end
      S_FNX: begin
        alu_q = '{a: OFF_W'(blk), b: OFF_W'(hb.size), sub: 1'b0};
        raddr = e_c[IDX_W-1:0];
        if (e_c >= ht) begin
          we          = 1'b1;
          wdata.start = 1'b0;
        end
      end
      S_FNE: begin
        we    = 1'b1;
        waddr = na;
        wdata = rd;
        raddr = nn2_c[IDX_W-1:0];
        if (rd.is_free) begin
          wdata.start = 1'b0;
        end else begin
          wdata.has_prev = 1'b1;
          wdata.prev     = blk;
        end
      end
      S_FLK: begin
        we    = 1'b1;
        waddr = nb;
        wdata = rd;
        wdata.has_prev = 1'b1;
        wdata.prev     = blk;
      end
      S_FWB: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr   <= '0;
      ht    <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == IDX_W'(NG - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            need      <= need_c;
            p         <= in_addr;
            o         <= '0;
            have_last <= 1'b0;
            state     <= in_cmd ? S_FCHK : S_WALK;
          end
        end
        S_WALK: begin
          state <= (o < ht) ? S_WEV : S_NOFIT;
        end
        S_WEV: begin
          if (!rd.start) begin
            state <= S_NOFIT;
          end else if (rd.is_free && alu_r.carry) begin
            hb    <= rd;
            state <= S_FOUND;
          end else begin
            last      <= o[IDX_W-1:0];
            have_last <= 1'b1;
            o         <= walk_end;
            state     <= S_WALK;
          end
        end
        S_FOUND: begin
          hb.is_free <= 1'b0;
          na         <= n_c[IDX_W-1:0];
          nb         <= nn_c[IDX_W-1:0];
          if (split_c) begin
            hb.size <= need[IDX_W-1:0];
          end
          state <= (split_c && nn_c < ht) ? S_SPLW : S_FINO;
        end
        S_SPLW: begin
          state <= S_FINO;
        end
        S_FINO: begin
          res   <= '{addr: pay_addr(o), status: ST_OK};
          state <= S_DONE;
        end
        S_NOFIT: begin
          if (fit_ok) begin
            res <= '{addr: pay_addr(ht), status: ST_OK};
            ht  <= top_c[OFF_W-1:0];
          end else begin
            res <= '{addr: '0, status: ST_OOM};
          end
          state <= S_DONE;
        end
        S_FCHK: begin
          if (bad_c) begin
            res   <= '{addr: '0, status: ST_BAD};
            state <= S_DONE;
          end else begin
            blk   <= b_c;
            state <= S_FEV;
          end
        end
        S_FEV: begin
          if (!rd.start) begin
            res   <= '{addr: '0, status: ST_BAD};
            state <= S_DONE;
          end else if (rd.is_free) begin
            res   <= '{addr: '0, status: ST_DBL};
            state <= S_DONE;
          end else begin
            hb    <= '{start: rd.start, is_free: 1'b1, has_prev: rd.has_prev,
                       size: rd.size, prev: rd.prev};
            na    <= rd.prev;
            state <= (rd.has_prev && OFF_W'(rd.prev) < ht) ? S_FPV : S_FNX;
          end
        end
        S_FPV: begin
          if (rd.start && rd.is_free) begin
            hb  <= '{start: rd.start, is_free: rd.is_free, has_prev: rd.has_prev,
                     size: IDX_W'(OFF_W'(rd.size) + OFF_W'(hb.size) + OFF_W'(HDR_G)),
                     prev: rd.prev};
            blk <= na;
          end
          state <= S_FNX;
        end
        S_FNX: begin
          if (e_c < ht) begin
            na    <= e_c[IDX_W-1:0];
            state <= S_FNE;
          end else begin
            ht    <= OFF_W'(blk);
            res   <= '{addr: '0, status: ST_OK};
            state <= S_DONE;
          end
        end
        S_FNE: begin
          if (rd.is_free) begin
            hb.size <= IDX_W'(OFF_W'(hb.size) + OFF_W'(rd.size) + OFF_W'(HDR_G));
            nb      <= nn2_c[IDX_W-1:0];
            state   <= (nn2_c < ht) ? S_FLK : S_FWB;
          end else begin
            state <= S_FWB;
          end
        end
        S_FLK: begin
          state <= S_FWB;
        end
        S_FWB: begin
          res   <= '{addr: '0, status: ST_OK};
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFA_ASSERT_IMP(a_top_in_arena, 1'b1, ht <= OFF_W'(NG), "heap top past arena")
  `FFA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready,
                   "ready straight after request")
  `FFA_ASSERT_IMP(a_err_addr_zero, done && res.status != ST_OK, res.addr == '0,
                  "error result with nonzero address")
  `FFA_ASSERT_NEXT(a_oom_keeps_top, state == S_NOFIT && !fit_ok, ht == $past(ht),
                   "heap top moved on out of memory")

endmodule

// ----- sv/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator over a 64 KiB arena with 40-byte block headers.
// After reset every entry of the header memory is cleared before the first
// request is taken. An allocate request walks the blocks in the header memory,
// takes the first free block that fits, splitting it when the rest is large
// enough, or else appends a block at the heap top or reports out of memory; a
// free request checks the address and merges and relinks free neighbours.
// Requests are handled one at a time; the result register lets the next
// request in while a result waits to be taken.
// Depends on ffa_pkg, ffa_alu and ffa_seq.
module first_fit_heap_allocator_top
  import ffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_size [15:0], free_addr [31:16]
  input  logic        s_axis_tuser,   // cmd: 0 allocate, 1 free
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // result_addr [15:0], status [17:16], zeros
);

  alu_req_t alu_q;
  alu_rsp_t alu_r;
  logic     done;
  logic     done_ack;
  res_t     res;

  ffa_alu u_alu (
    .q (alu_q),
    .r (alu_r)
  );

  ffa_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_size  (s_axis_tdata[15:0]),
    .in_addr  (s_axis_tdata[31:16]),
    .alu_q    (alu_q),
    .alu_r    (alu_r),
    .done     (done),
    .res      (res),
    .done_ack (done_ack)
  );

  assign done_ack = done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done_ack) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {6'b0, res.status, res.addr};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

// ----- tb/alloc_cmd_pkg.sv -----
// request kinds carried on tuser of the allocator's request channel
// shared by the testbench top and the checker, no dependencies
package alloc_cmd_pkg;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } alloc_cmd_t;

endpackage

// ----- tb/heap_checker.sv -----
// watches both channels of the allocator, keeps its own copy of the heap layout
// and compares every result with the predicted one; depends on ffa_pkg, alloc_cmd_pkg
`timescale 1ns / 1ps
module heap_checker
  import ffa_pkg::*;
  import alloc_cmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          errors,
  output int          pending
);

  localparam int NGRAN = ARENA_BYTES / 8;

  bit blk_start [NGRAN];
  bit blk_free  [NGRAN];
  bit blk_hprev [NGRAN];
  int blk_size  [NGRAN];
  int blk_prev  [NGRAN];
  int heap_end;

  res_t expected_q[$];

  initial begin
    for (int i = 0; i < NGRAN; i++) begin
      blk_start[i] = 0;
      blk_free[i] = 0;
      blk_hprev[i] = 0;
      blk_size[i] = 0;
      blk_prev[i] = 0;
    end
    heap_end = 0;
    errors = 0;
  end

  assign pending = expected_q.size();

  function automatic int block_end(int b);
    return b + HEADER_BYTES + blk_size[b >> 3];
  endfunction

  function automatic void merge_next(int b);
    int n;
    int nn;
    n = block_end(b);
    if (blk_free[b >> 3] && n < heap_end && blk_free[n >> 3]) begin
      blk_size[b >> 3] += blk_size[n >> 3] + HEADER_BYTES;
      blk_start[n >> 3] = 0;
      nn = block_end(b);
      if (nn < heap_end) begin
        blk_prev[nn >> 3] = b;
        blk_hprev[nn >> 3] = 1;
      end
    end
  endfunction

  function automatic res_t heap_request(alloc_cmd_t c, int rsz, int fa);
    res_t r;
    int need;
    int o;
    int last;
    bit have_last;
    bit found;
    int n;
    int nn;
    int b;
    int pv;
    r.addr = '0;
    r.status = ST_OK;
    if (c == CMD_ALLOC) begin
      need = rsz;
      if (need & 7) need += 8 - (need & 7);
      o = 0;
      last = 0;
      have_last = 0;
      found = 0;
      while (o < heap_end && blk_start[o >> 3]) begin
        if (blk_free[o >> 3] && blk_size[o >> 3] >= need) begin
          found = 1;
          break;
        end
        last = o;
        have_last = 1;
        o = block_end(o);
      end
      if (found) begin
        if (blk_size[o >> 3] - need > HEADER_BYTES + 8) begin
          n = o + HEADER_BYTES + need;
          nn = block_end(o);
          blk_start[n >> 3] = 1;
          blk_free[n >> 3] = 1;
          blk_hprev[n >> 3] = 1;
          blk_prev[n >> 3] = o;
          blk_size[n >> 3] = blk_size[o >> 3] - need - HEADER_BYTES;
          if (nn < heap_end) begin
            blk_prev[nn >> 3] = n;
            blk_hprev[nn >> 3] = 1;
          end
          blk_size[o >> 3] = need;
        end
        blk_free[o >> 3] = 0;
        r.addr = 16'(o + HEADER_BYTES);
      end else if (heap_end + HEADER_BYTES + need > ARENA_BYTES) begin
        r.status = ST_OOM;
      end else begin
        blk_start[heap_end >> 3] = 1;
        blk_free[heap_end >> 3] = 0;
        blk_size[heap_end >> 3] = need;
        blk_hprev[heap_end >> 3] = have_last;
        blk_prev[heap_end >> 3] = have_last ? last : 0;
        r.addr = 16'(heap_end + HEADER_BYTES);
        heap_end += HEADER_BYTES + need;
      end
      return r;
    end
    b = fa - HEADER_BYTES;
    if (heap_end == 0 || fa < HEADER_BYTES || fa >= heap_end || (b & 7) != 0 ||
        !blk_start[b >> 3]) begin
      r.status = ST_BAD;
      return r;
    end
    if (blk_free[b >> 3]) begin
      r.status = ST_DBL;
      return r;
    end
    blk_free[b >> 3] = 1;
    if (blk_hprev[b >> 3]) begin
      pv = blk_prev[b >> 3];
      if (pv < heap_end && blk_start[pv >> 3] && blk_free[pv >> 3]) begin
        merge_next(pv);
        b = pv;
      end
    end
    if (block_end(b) < heap_end) begin
      merge_next(b);
    end else begin
      blk_start[b >> 3] = 0;
      heap_end = b;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(heap_request(alloc_cmd_t'(s_axis_tuser),
                                          int'(s_axis_tdata[15:0]),
                                          int'(s_axis_tdata[31:16])));
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr = m_axis_tdata[15:0];
        got.status = status_t'(m_axis_tdata[17:16]);
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result addr %0d status %s", $time, got.addr,
                   got.status.name());
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.addr !== want.addr || got.status !== want.status ||
              m_axis_tdata[23:18] !== 6'd0) begin
            $display("%0t: mismatch expected addr %0d status %s, got addr %0d status %s pad %0h",
                     $time, want.addr, want.status.name(), got.addr, got.status.name(),
                     m_axis_tdata[23:18]);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
// drives allocate and free requests into the first-fit allocator under
// several idling phases; depends on ffa_pkg, alloc_cmd_pkg, the allocator top and heap_checker
`timescale 1ns / 1ps
module testbench;
  import ffa_pkg::*;
  import alloc_cmd_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;

  int errors;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int n_alloc = 0;
  int n_free = 0;
  logic [15:0] live_q[$];
  logic [15:0] last_freed = 16'd40;

  always #2 clk = ~clk;

  first_fit_heap_allocator_top dut (.*);

  heap_checker chk (.*);

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // remember granted payloads so frees can target live blocks
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tdata[17:16] == ST_OK &&
        m_axis_tdata[15:0] != 16'd0)
      live_q.push_back(m_axis_tdata[15:0]);

  task automatic send(alloc_cmd_t c, logic [15:0] rsz, logic [15:0] fa);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= c;
    s_axis_tdata <= {fa, rsz};
    if (c == CMD_ALLOC) n_alloc++;
    else n_free++;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic random_request();
    int r;
    int k;
    logic [15:0] a;
    r = $urandom_range(99);
    if (r < 50 || live_q.size() == 0) begin
      r = $urandom_range(99);
      if (r < 80) send(CMD_ALLOC, 16'($urandom_range(0, 120)), 16'($urandom()));
      else if (r < 95) send(CMD_ALLOC, 16'($urandom_range(0, 2000)), 16'($urandom()));
      else send(CMD_ALLOC, 16'($urandom()), 16'($urandom()));
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        k = $urandom_range(0, live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        last_freed = a;
      end else if (r < 80) begin
        a = 16'($urandom());
      end else if (r < 90) begin
        a = 16'($urandom_range(0, 4096) & ~7);
      end else begin
        a = last_freed;
      end
      send(CMD_FREE, 16'($urandom()), a);
    end
  endtask

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed: empty free, zero size, rounding, overflow, merges, last block
    send(CMD_FREE, 16'd0, 16'd40);
    send(CMD_ALLOC, 16'd0, 16'd0);
    send(CMD_ALLOC, 16'd1, 16'hffff);
    send(CMD_ALLOC, 16'd8, 16'd0);
    send(CMD_ALLOC, 16'd100, 16'd0);
    send(CMD_ALLOC, 16'd65535, 16'd0);
    send(CMD_FREE, 16'hffff, 16'd0);
    send(CMD_FREE, 16'd0, 16'd39);
    send(CMD_FREE, 16'd0, 16'd65535);
    send(CMD_FREE, 16'd0, 16'd89);
    send(CMD_FREE, 16'd0, 16'd88);
    send(CMD_FREE, 16'd0, 16'd88);
    send(CMD_FREE, 16'd0, 16'd136);
    send(CMD_ALLOC, 16'd4, 16'd0);
    send(CMD_FREE, 16'd0, 16'd184);
    send(CMD_ALLOC, 16'd200, 16'd0);
    send(CMD_ALLOC, 16'd64000, 16'd0);
    send(CMD_ALLOC, 16'd2000, 16'd0);
    send(CMD_FREE, 16'd0, 16'd40);
    send(CMD_FREE, 16'd0, 16'd88);
    send(CMD_FREE, 16'd0, 16'd336);
    send(CMD_FREE, 16'd0, 16'd136);
    send(CMD_ALLOC, 16'd0, 16'd0);
    send(CMD_FREE, 16'd0, 16'd40);
    s_axis_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    live_q.delete();
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 29 : 60) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 29 : 60) : 0;
      for (int i = 0; i < 100; i++) random_request();
    end
    s_axis_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d allocate and %0d free requests", n_alloc, n_free);
    $display("phases: no idling, sender gaps, receiver stalls, both together");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
